// ===== hw/rtl/knnbc_pkg.sv =====
// Shared types and constants for the k-nearest-neighbour classifier.
package knnbc_pkg;

  localparam int MAX_TRAIN_VECTORS = 256;
  localparam int MAX_FEATURES      = 16;
  localparam int MAX_K             = 15;
  localparam int FEATURE_BITS      = 16;

  localparam int POS_W   = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
  localparam int LEN_W   = $clog2(MAX_FEATURES + 1);
  localparam int VI_W    = (MAX_TRAIN_VECTORS > 1) ? $clog2(MAX_TRAIN_VECTORS) : 1;
  localparam int CNT_W   = $clog2(MAX_TRAIN_VECTORS + 1);
  localparam int TADDR_W = $clog2(MAX_TRAIN_VECTORS * MAX_FEATURES);
  localparam int K_W     = $clog2(MAX_K + 1);
  localparam int SQ_W    = 2 * FEATURE_BITS;
  localparam int DIST_W  = SQ_W + $clog2(MAX_FEATURES) + 1;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 5;
  localparam int NC_W    = 4;
  localparam int VL_W    = 5;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_TRAIN = 2'd1,
    OP_QUERY = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NEIGHBOUR_COUNT = 1'b0,
    REG_VECTOR_LENGTH   = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic [1:0]                     operation;
    logic signed [FEATURE_BITS-1:0] feature_value;
    logic                           class_label;
  } in_t;

  typedef struct packed {
    logic       predicted_class;
    logic [3:0] vote_count;
    logic [3:0] neighbours_used;
    logic       empty_store;
    logic       store_overflow;
  } out_t;

  // candidate distance broadcast to the cell row
  typedef struct packed {
    logic              vld;
    logic [DIST_W-1:0] dsum;
    logic              lbl;
  } cand_t;

  // contents of one neighbour slot
  typedef struct packed {
    logic              vld;
    logic [DIST_W-1:0] dsum;
    logic              lbl;
  } slot_t;

endpackage

// ===== hw/rtl/knnbc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module knnbc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/knnbc_cell.sv =====
// One slot of the sorted nearest-neighbour row.
module knnbc_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              clear,
  input  logic              enable,
  input  knnbc_pkg::cand_t  cand,
  input  knnbc_pkg::slot_t  prev,
  input  logic              prev_less,
  output knnbc_pkg::slot_t  slot,
  output logic              less
);
  import knnbc_pkg::*;

  logic              vld_r, vld_nxt;
  logic [DIST_W-1:0] dist_r, dist_nxt;
  logic              lbl_r, lbl_nxt;
  logic              take;

  // strict compare: on a tie the earlier entry stays ahead
  assign less = !vld_r || (cand.dsum < dist_r);
  assign take = cand.vld && enable && less;

  always_comb begin
    vld_nxt  = vld_r;
    dist_nxt = dist_r;
    lbl_nxt  = lbl_r;
    if (clear) begin
      vld_nxt = 1'b0;
    end else if (take) begin
      if (prev_less) begin
        vld_nxt  = prev.vld;
        dist_nxt = prev.dsum;
        lbl_nxt  = prev.lbl;
      end else begin
        vld_nxt  = 1'b1;
        dist_nxt = cand.dsum;
        lbl_nxt  = cand.lbl;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
    dist_r <= dist_nxt;
    lbl_r  <= lbl_nxt;
  end

  assign slot = '{vld: vld_r, dsum: dist_r, lbl: lbl_r};

endmodule

// ===== hw/rtl/knn_binary_classifier_core.sv =====
// Top level of the k-nearest-neighbour classifier: loading, distance pipeline, cell row.
//
// Input channel (in_valid/in_stall/in_data) carries one beat per operation:
// clear, training feature or query feature. Training features go to the
// feature RAM; the last feature of a vector commits its label. The last
// query feature starts a scan: every stored vector is read one feature per
// cycle, squared differences are accumulated, and each finished distance is
// offered to a row of neighbour cells that keeps the k nearest in order.
// The feature RAM read port, one feature per cycle, sets the length of a
// scan. An empty store answers at once, in the cycle after the query beat.
// One result beat follows each completed query on out_valid/out_data and is
// held while out_stall is high; training beats are still taken meanwhile,
// but a query beat waits until the result has gone. in_stall is high during
// a scan. Configuration writes (cfg_valid/cfg_ready, always ready) are meant
// for idle periods. Reset empties the store, clears the position and the
// overflow flag, and sets k to 1 and the vector length to 16; no clearing
// pass is needed.
module knn_binary_classifier_core (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  knnbc_pkg::in_t                        in_data,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output knnbc_pkg::out_t                       out_data,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [knnbc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [knnbc_pkg::CFG_DAT_W-1:0]       cfg_data
);
  import knnbc_pkg::*;

  // configuration
  logic [NC_W-1:0] nc_r;
  logic [VL_W-1:0] vl_r;

  // loading state
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             ovf_r, ovf_nxt;
  logic [FEATURE_BITS-1:0] qbuf_r [MAX_FEATURES];

  // scan control
  state_t           state_r, state_nxt;
  logic [VI_W-1:0]  vi_r, vi_nxt;
  logic [POS_W-1:0] fi_r, fi_nxt;
  logic [CNT_W-1:0] n_r, n_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [K_W-1:0]   k_r, k_nxt;

  // pipeline
  logic             s1_vld_r, s1_first_r, s1_last_r;
  logic [POS_W-1:0] s1_fi_r;
  logic             s2_vld_r, s2_first_r, s2_last_r, s2_lbl_r;
  logic [SQ_W-1:0]  sq_r;
  logic [DIST_W-1:0] acc_r, acc_nxt;
  cand_t            cand_r;

  logic             out_valid_r;
  out_t             out_r;

  logic             in_acc, issue, start_scan, emit_empty, emit_scan;
  logic [LEN_W-1:0] len_eff;
  logic             last_feat, room;
  logic [K_W-1:0]   k_req, k_lim, k_eff;
  logic [CNT_W-1:0] lim;

  logic                    tf_we;
  logic [TADDR_W-1:0]      tf_waddr, tf_raddr;
  logic [FEATURE_BITS-1:0] tf_rdata;
  logic                    tl_we;
  logic [VI_W-1:0]         tl_waddr;
  logic                    tl_rdata;

  logic signed [FEATURE_BITS:0] diff;
  logic [FEATURE_BITS-1:0]      absd;

  slot_t slots [MAX_K];
  logic  lesses [MAX_K];
  logic [K_W-1:0] votes;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != ST_IDLE) ||
                     (out_valid_r && (in_data.operation == OP_QUERY));
  assign in_acc    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nc_r <= NC_W'(1);
      vl_r <= VL_W'(MAX_FEATURES);
    end else if (cfg_valid && cfg_ready) begin
      case (reg_idx_t'(cfg_index))
        REG_NEIGHBOUR_COUNT: nc_r <= cfg_data[NC_W-1:0];
        REG_VECTOR_LENGTH:   vl_r <= cfg_data[VL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (vl_r == '0) begin
      len_eff = LEN_W'(1);
    end else if (vl_r > VL_W'(MAX_FEATURES)) begin
      len_eff = LEN_W'(MAX_FEATURES);
    end else begin
      len_eff = vl_r[LEN_W-1:0];
    end
  end

  assign last_feat = ({1'b0, pos_r} + (POS_W+1)'(1)) >= (POS_W+1)'(len_eff);
  assign room      = count_r < CNT_W'(MAX_TRAIN_VECTORS);

  // effective k: clamp, then limit to the largest odd number not above the count
  always_comb begin
    k_req = (nc_r == '0) ? K_W'(1) :
            (nc_r > NC_W'(MAX_K)) ? K_W'(MAX_K) : K_W'(nc_r);
    lim   = count_r[0] ? count_r : count_r - CNT_W'(1);
    k_lim = (lim < CNT_W'(MAX_K)) ? lim[K_W-1:0] : K_W'(MAX_K);
    k_eff = (k_req > k_lim) ? k_lim : k_req;
  end

  // loading
  always_comb begin
    count_nxt = count_r;
    pos_nxt   = pos_r;
    ovf_nxt   = ovf_r;
    tf_we     = 1'b0;
    tl_we     = 1'b0;
    start_scan = 1'b0;
    emit_empty = 1'b0;
    if (in_acc) begin
      case (op_t'(in_data.operation))
        OP_CLEAR: begin
          count_nxt = '0;
          pos_nxt   = '0;
          ovf_nxt   = 1'b0;
        end
        OP_TRAIN: begin
          tf_we = room;
          if (last_feat) begin
            pos_nxt = '0;
            if (room) begin
              tl_we     = 1'b1;
              count_nxt = count_r + CNT_W'(1);
            end else begin
              ovf_nxt = 1'b1;
            end
          end else begin
            pos_nxt = pos_r + POS_W'(1);
          end
        end
        OP_QUERY: begin
          if (last_feat) begin
            pos_nxt = '0;
            if (count_r == '0) begin
              emit_empty = 1'b1;
            end else begin
              start_scan = 1'b1;
            end
          end else begin
            pos_nxt = pos_r + POS_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  assign tf_waddr = TADDR_W'(count_r[VI_W-1:0]) * TADDR_W'(MAX_FEATURES) + TADDR_W'(pos_r);
  assign tl_waddr = count_r[VI_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      pos_r   <= '0;
      ovf_r   <= 1'b0;
    end else begin
      count_r <= count_nxt;
      pos_r   <= pos_nxt;
      ovf_r   <= ovf_nxt;
    end
    if (in_acc && (in_data.operation == OP_QUERY)) begin
      qbuf_r[pos_r] <= in_data.feature_value;
    end
  end

  // scan sequencer
  always_comb begin
    state_nxt = state_r;
    vi_nxt    = vi_r;
    fi_nxt    = fi_r;
    n_nxt     = n_r;
    len_nxt   = len_r;
    k_nxt     = k_r;
    issue     = 1'b0;
    emit_scan = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (start_scan) begin
          state_nxt = ST_RUN;
          vi_nxt    = '0;
          fi_nxt    = '0;
          n_nxt     = count_r;
          len_nxt   = len_eff;
          k_nxt     = k_eff;
        end
      end
      ST_RUN: begin
        issue = 1'b1;
        if ((POS_W+1)'(fi_r) == (POS_W+1)'(len_r - LEN_W'(1))) begin
          fi_nxt = '0;
          if (CNT_W'(vi_r) == n_r - CNT_W'(1)) begin
            state_nxt = ST_DRAIN;
          end else begin
            vi_nxt = vi_r + VI_W'(1);
          end
        end else begin
          fi_nxt = fi_r + POS_W'(1);
        end
      end
      ST_DRAIN: begin
        if (!s1_vld_r && !s2_vld_r && !cand_r.vld) begin
          emit_scan = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    vi_r  <= vi_nxt;
    fi_r  <= fi_nxt;
    n_r   <= n_nxt;
    len_r <= len_nxt;
    k_r   <= k_nxt;
  end

  assign tf_raddr = TADDR_W'(vi_r) * TADDR_W'(MAX_FEATURES) + TADDR_W'(fi_r);

  knnbc_ram #(.WIDTH(FEATURE_BITS), .DEPTH(MAX_TRAIN_VECTORS * MAX_FEATURES)) u_feat_ram (
    .clk   (clk),
    .we    (tf_we),
    .waddr (tf_waddr),
    .wdata (in_data.feature_value),
    .raddr (tf_raddr),
    .rdata (tf_rdata)
  );

  knnbc_ram #(.WIDTH(1), .DEPTH(MAX_TRAIN_VECTORS)) u_label_ram (
    .clk   (clk),
    .we    (tl_we),
    .waddr (tl_waddr),
    .wdata (in_data.class_label),
    .raddr (vi_r),
    .rdata (tl_rdata)
  );

  // distance pipeline: read, square, accumulate
  assign diff = $signed({qbuf_r[s1_fi_r][FEATURE_BITS-1], qbuf_r[s1_fi_r]}) -
                $signed({tf_rdata[FEATURE_BITS-1], tf_rdata});
  assign absd = diff[FEATURE_BITS] ? FEATURE_BITS'(-diff) : diff[FEATURE_BITS-1:0];
  assign acc_nxt = (s2_first_r ? '0 : acc_r) + DIST_W'(sq_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r   <= 1'b0;
      s2_vld_r   <= 1'b0;
      cand_r.vld <= 1'b0;
    end else begin
      s1_vld_r   <= issue;
      s2_vld_r   <= s1_vld_r;
      cand_r.vld <= s2_vld_r && s2_last_r;
    end
    s1_first_r  <= (fi_r == '0);
    s1_last_r   <= ((POS_W+1)'(fi_r) == (POS_W+1)'(len_r - LEN_W'(1)));
    s1_fi_r     <= fi_r;
    s2_first_r  <= s1_first_r;
    s2_last_r   <= s1_last_r;
    s2_lbl_r    <= tl_rdata;
    sq_r        <= absd * absd;
    if (s2_vld_r) begin
      acc_r <= acc_nxt;
    end
    cand_r.dsum <= acc_nxt;
    cand_r.lbl  <= s2_lbl_r;
  end

  // neighbour row
  for (genvar j = 0; j < MAX_K; j++) begin : g_cell
    if (j == 0) begin : g_head
      knnbc_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .clear     (start_scan),
        .enable    (K_W'(j) < k_r),
        .cand      (cand_r),
        .prev      ('0),
        .prev_less (1'b0),
        .slot      (slots[j]),
        .less      (lesses[j])
      );
    end else begin : g_body
      knnbc_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .clear     (start_scan),
        .enable    (K_W'(j) < k_r),
        .cand      (cand_r),
        .prev      (slots[j-1]),
        .prev_less (lesses[j-1]),
        .slot      (slots[j]),
        .less      (lesses[j])
      );
    end
  end

  always_comb begin
    votes = '0;
    for (int j = 0; j < MAX_K; j++) begin
      votes = votes + K_W'(slots[j].vld && slots[j].lbl);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_empty || emit_scan) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (emit_empty) begin
      out_r <= '{predicted_class: 1'b0, vote_count: 4'd0, neighbours_used: 4'd0,
                 empty_store: 1'b1, store_overflow: ovf_r};
    end else if (emit_scan) begin
      out_r <= '{predicted_class: ({votes, 1'b0} > {1'b0, k_r}),
                 vote_count: votes[3:0], neighbours_used: k_r[3:0],
                 empty_store: 1'b0, store_overflow: ovf_r};
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> in_stall)
    else $error("input taken during scan");
  a_cand_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    cand_r.vld |-> (state_r == ST_DRAIN || state_r == ST_RUN))
    else $error("distance outside scan");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_TRAIN_VECTORS))
    else $error("store count past capacity");
  a_no_double_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !(emit_empty || emit_scan))
    else $error("result overwritten");
`endif

endmodule
